@@ rtl/core/tach_pkg.sv @@
package tach_pkg;

    // Field widths
    localparam int SAMPLE_W  = 10;
    localparam int PERIOD_W  = 16;
    localparam int THR_W     = 10;
    localparam int TAPE_W    = 5;
    localparam int CNT_W     = 24;
    localparam int RPM_W     = 32;
    localparam int WHOLE_W   = 16;
    localparam int RPS_W     = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 10;

    // Averaging window
    localparam int WINDOW_SIZE = 8;
    localparam int WIN_AW      = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int SUM_W       = SAMPLE_W + $clog2(WINDOW_SIZE);

    // Rate arithmetic: count * 60000 * 16 / (tapes * ms)
    localparam int RATE_CONST = 960000;
    localparam int RC_W       = 20;
    localparam int NUM_W      = CNT_W + RC_W;
    localparam int DEN_W      = TAPE_W + PERIOD_W;
    localparam int DIV_CW     = $clog2(NUM_W);
    localparam int CLOSE_LIM  = 2;

    // Display conversion: whole rpm drops 4 fraction bits, rps divides by 960
    localparam int FRAC_W      = 4;
    localparam int RPS_SAT_LIM = 256 * 960;
    localparam int RPS_SHIFT   = 6;
    localparam int RPS_X_W     = 12;
    localparam int RECIP_15    = 17477;
    localparam int RECIP_W     = 15;
    localparam int RECIP_SH    = 18;
    localparam int RPS_PW      = RPS_X_W + RECIP_W;

    // Register reset values and indexes
    localparam logic [THR_W-1:0]     THR_RESET  = THR_W'(20);
    localparam logic [TAPE_W-1:0]    TAPE_RESET = TAPE_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THR   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAPE_COUNT = 1'b1;

    // Item kinds
    localparam logic ACT_SAMPLE  = 1'b0;
    localparam logic ACT_COMPUTE = 1'b1;

    typedef struct packed {
        logic capture;
        logic push;
        logic edge_upd;
        logic div_init;
        logic div_step;
        logic avg_upd;
        logic load_out;
    } tach_cmd_t;

    typedef struct packed {
        logic is_compute;
        logic div_last;
    } tach_sts_t;

endpackage

@@ rtl/core/tach_ctrl.sv @@
module tach_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  tach_pkg::tach_sts_t sts,
    output tach_pkg::tach_cmd_t cmd
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_PUSH = 7'b0000010,
        ST_EDGE = 7'b0000100,
        ST_MULT = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_AVG  = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   valid_reg, valid_next;
    logic   out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = valid_reg;
    assign out_free = !valid_reg || m_ready;

    // Sequence one item at a time
    always_comb begin
        state_next = state_reg;
        valid_next = valid_reg;
        cmd        = '0;
        if (valid_reg && m_ready) begin
            valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (sts.is_compute == tach_pkg::ACT_COMPUTE) begin
                    state_next = ST_MULT;
                end else begin
                    cmd.push   = 1'b1;
                    state_next = ST_EDGE;
                end
            end
            ST_EDGE: begin
                cmd.edge_upd = 1'b1;
                state_next   = ST_OUT;
            end
            ST_MULT: begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_AVG;
                end
            end
            ST_AVG: begin
                cmd.avg_upd = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                // Hold the finished item until the result register frees up
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule

@@ rtl/core/tach_dp.sv @@
module tach_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tach_pkg::tach_cmd_t                 cmd,
    output tach_pkg::tach_sts_t                 sts,
    input  logic                                cfg_we,
    input  logic [tach_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tach_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                s_action,
    input  logic [tach_pkg::SAMPLE_W-1:0]       s_sample,
    input  logic [tach_pkg::PERIOD_W-1:0]       s_period_ms,
    output logic [tach_pkg::CNT_W-1:0]          m_rising_count,
    output logic [tach_pkg::CNT_W-1:0]          m_falling_count,
    output logic                                m_is_high,
    output logic                                m_is_low,
    output logic [tach_pkg::RPM_W-1:0]          m_rpm_fixed,
    output logic [tach_pkg::WHOLE_W-1:0]        m_rpm_whole,
    output logic [tach_pkg::RPS_W-1:0]          m_rps_byte
);

    localparam int EW = tach_pkg::SUM_W + 1;

    // Configuration
    logic [tach_pkg::THR_W-1:0]    thr_reg;
    logic [tach_pkg::TAPE_W-1:0]   tape_reg;

    // Captured item
    logic                          act_reg;
    logic [tach_pkg::SAMPLE_W-1:0] smp_reg;
    logic [tach_pkg::PERIOD_W-1:0] per_reg;

    // Tachometer state
    logic [tach_pkg::SAMPLE_W-1:0] win_reg [tach_pkg::WINDOW_SIZE];
    logic [tach_pkg::SUM_W-1:0]    sum_reg;
    logic [tach_pkg::WIN_AW-1:0]   pos_reg;
    logic                          high_reg;
    logic                          low_reg;
    logic [tach_pkg::CNT_W-1:0]    rise_reg;
    logic [tach_pkg::CNT_W-1:0]    fall_reg;
    logic [tach_pkg::RPM_W-1:0]    rpm_reg;

    // Divider lanes: 0 for rising, 1 for falling
    logic [tach_pkg::NUM_W-1:0]    quo_reg [2];
    logic [tach_pkg::DEN_W-1:0]    rem_reg [2];
    logic [tach_pkg::NUM_W-1:0]    quo_next [2];
    logic [tach_pkg::DEN_W-1:0]    rem_next [2];
    logic [tach_pkg::DEN_W-1:0]    den_reg;
    logic [tach_pkg::DIV_CW-1:0]   dcnt_reg;

    // Result register
    logic [tach_pkg::CNT_W-1:0]    o_rise_reg;
    logic [tach_pkg::CNT_W-1:0]    o_fall_reg;
    logic                          o_high_reg;
    logic                          o_low_reg;
    logic [tach_pkg::RPM_W-1:0]    o_rpm_reg;
    logic [tach_pkg::WHOLE_W-1:0]  o_whole_reg;
    logic [tach_pkg::RPS_W-1:0]    o_rps_reg;

    logic [tach_pkg::SUM_W-1:0]    sum_next;
    logic [EW-1:0]                 scaled;
    logic [EW-1:0]                 margin;
    logic [EW-1:0]                 sum_ext;
    logic                          cross_up;
    logic                          cross_dn;
    logic [tach_pkg::TAPE_W-1:0]   tapes;
    logic [tach_pkg::PERIOD_W-1:0] ms;
    logic [tach_pkg::DEN_W:0]      rem_sh [2];
    logic                          ge [2];
    logic [tach_pkg::RPM_W-1:0]    rate_sat [2];
    logic [tach_pkg::RPM_W:0]      rate_sum;
    logic [tach_pkg::CNT_W-1:0]    cnt_diff;
    logic                          close;
    logic [tach_pkg::WHOLE_W-1:0]  whole_c;
    logic [tach_pkg::RPS_X_W-1:0]  rps_x;
    logic [tach_pkg::RPS_PW-1:0]   rps_prod;
    logic [tach_pkg::RPS_W-1:0]    rps_c;

    assign sts.is_compute = act_reg;
    assign sts.div_last   = (dcnt_reg == '0);

    // Window sum with the newest sample replacing the oldest
    assign sum_next = sum_reg - tach_pkg::SUM_W'(win_reg[pos_reg])
                      + tach_pkg::SUM_W'(smp_reg);

    // Compare sample*N against sum +/- threshold*N
    assign scaled   = EW'(smp_reg) * EW'(tach_pkg::WINDOW_SIZE);
    assign margin   = EW'(thr_reg) * EW'(tach_pkg::WINDOW_SIZE);
    assign sum_ext  = EW'(sum_reg);
    assign cross_up = scaled > (sum_ext + margin);
    assign cross_dn = (scaled + margin) < sum_ext;

    // Zero tape count and zero period count as one
    assign tapes = (tape_reg == '0) ? tach_pkg::TAPE_W'(1) : tape_reg;
    assign ms    = (per_reg == '0) ? tach_pkg::PERIOD_W'(1) : per_reg;

    // One restoring division step per lane
    always_comb begin
        for (int i = 0; i < 2; i++) begin
            rem_sh[i] = {rem_reg[i], quo_reg[i][tach_pkg::NUM_W-1]};
            ge[i]     = rem_sh[i] >= {1'b0, den_reg};
            rem_next[i] = ge[i] ? tach_pkg::DEN_W'(rem_sh[i] - {1'b0, den_reg})
                                : rem_sh[i][tach_pkg::DEN_W-1:0];
            quo_next[i] = {quo_reg[i][tach_pkg::NUM_W-2:0], ge[i]};
            rate_sat[i] = (|quo_reg[i][tach_pkg::NUM_W-1:tach_pkg::RPM_W]) ? '1
                          : quo_reg[i][tach_pkg::RPM_W-1:0];
        end
    end

    // Average the two rates when the counts agree within two
    assign rate_sum = {1'b0, rate_sat[0]} + {1'b0, rate_sat[1]};
    assign cnt_diff = rise_reg - fall_reg;
    assign close    = (cnt_diff <= tach_pkg::CNT_W'(tach_pkg::CLOSE_LIM))
                   || (cnt_diff >= ~tach_pkg::CNT_W'(tach_pkg::CLOSE_LIM - 1));

    // Display values: whole rpm and rps by reciprocal multiply
    assign whole_c  = (|rpm_reg[tach_pkg::RPM_W-1:tach_pkg::WHOLE_W+tach_pkg::FRAC_W]) ? '1
                      : rpm_reg[tach_pkg::WHOLE_W+tach_pkg::FRAC_W-1:tach_pkg::FRAC_W];
    assign rps_x    = rpm_reg[tach_pkg::RPS_X_W+tach_pkg::RPS_SHIFT-1:tach_pkg::RPS_SHIFT];
    assign rps_prod = tach_pkg::RPS_PW'(rps_x) * tach_pkg::RPS_PW'(tach_pkg::RECIP_15);
    assign rps_c    = (rpm_reg >= tach_pkg::RPM_W'(tach_pkg::RPS_SAT_LIM)) ? '1
                      : rps_prod[tach_pkg::RECIP_SH+tach_pkg::RPS_W-1:tach_pkg::RECIP_SH];

    // Configuration and tachometer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= tach_pkg::THR_RESET;
            tape_reg <= tach_pkg::TAPE_RESET;
            for (int i = 0; i < tach_pkg::WINDOW_SIZE; i++) begin
                win_reg[i] <= '0;
            end
            sum_reg  <= '0;
            pos_reg  <= '0;
            high_reg <= 1'b0;
            low_reg  <= 1'b0;
            rise_reg <= '0;
            fall_reg <= '0;
            rpm_reg  <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    tach_pkg::CFG_EDGE_THR:   thr_reg  <= cfg_data[tach_pkg::THR_W-1:0];
                    tach_pkg::CFG_TAPE_COUNT: tape_reg <= cfg_data[tach_pkg::TAPE_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.push) begin
                win_reg[pos_reg] <= smp_reg;
                sum_reg          <= sum_next;
                if (pos_reg == tach_pkg::WIN_AW'(tach_pkg::WINDOW_SIZE - 1)) begin
                    pos_reg <= '0;
                end else begin
                    pos_reg <= pos_reg + 1'b1;
                end
            end
            if (cmd.edge_upd) begin
                if (cross_up) begin
                    if (!high_reg) begin
                        rise_reg <= rise_reg + 1'b1;
                    end
                    high_reg <= 1'b1;
                    low_reg  <= 1'b0;
                end else if (cross_dn) begin
                    if (!low_reg) begin
                        fall_reg <= fall_reg + 1'b1;
                    end
                    low_reg  <= 1'b1;
                    high_reg <= 1'b0;
                end
            end
            if (cmd.avg_upd && close) begin
                rpm_reg <= rate_sum[tach_pkg::RPM_W:1];
            end
        end
    end

    // Item capture, divider and result register
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            act_reg <= s_action;
            smp_reg <= s_sample;
            per_reg <= s_period_ms;
        end
        if (cmd.div_init) begin
            quo_reg[0] <= tach_pkg::NUM_W'(rise_reg)
                          * tach_pkg::NUM_W'(tach_pkg::RATE_CONST);
            quo_reg[1] <= tach_pkg::NUM_W'(fall_reg)
                          * tach_pkg::NUM_W'(tach_pkg::RATE_CONST);
            rem_reg[0] <= '0;
            rem_reg[1] <= '0;
            den_reg    <= tach_pkg::DEN_W'(tapes) * tach_pkg::DEN_W'(ms);
            dcnt_reg   <= tach_pkg::DIV_CW'(tach_pkg::NUM_W - 1);
        end else if (cmd.div_step) begin
            for (int i = 0; i < 2; i++) begin
                quo_reg[i] <= quo_next[i];
                rem_reg[i] <= rem_next[i];
            end
            dcnt_reg <= dcnt_reg - 1'b1;
        end
        if (cmd.load_out) begin
            o_rise_reg  <= rise_reg;
            o_fall_reg  <= fall_reg;
            o_high_reg  <= high_reg;
            o_low_reg   <= low_reg;
            o_rpm_reg   <= rpm_reg;
            o_whole_reg <= whole_c;
            o_rps_reg   <= rps_c;
        end
    end

    assign m_rising_count  = o_rise_reg;
    assign m_falling_count = o_fall_reg;
    assign m_is_high       = o_high_reg;
    assign m_is_low        = o_low_reg;
    assign m_rpm_fixed     = o_rpm_reg;
    assign m_rpm_whole     = o_whole_reg;
    assign m_rps_byte      = o_rps_reg;

endmodule

@@ rtl/core/tachometer_edge_rpm.sv @@
// Sequence: a sample item passes through the capture, push, edge and output states;
// a compute item through capture, multiply, the bit-serial rate divider (44 quotient bits, one bit a cycle),
// average and output. A new item is accepted only once the last has left the output state,
// and the output state waits while the result register is held by m_ready.
// Reset: synchronous active-low aresetn clears the window, sum, flags, counters
// and rpm, loads threshold 20 and tape count 1, and empties the result register.
module tachometer_edge_rpm (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [tach_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tach_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_action,
    input  logic [tach_pkg::SAMPLE_W-1:0]    s_sample,
    input  logic [tach_pkg::PERIOD_W-1:0]    s_period_ms,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [tach_pkg::CNT_W-1:0]       m_rising_count,
    output logic [tach_pkg::CNT_W-1:0]       m_falling_count,
    output logic                             m_is_high,
    output logic                             m_is_low,
    output logic [tach_pkg::RPM_W-1:0]       m_rpm_fixed,
    output logic [tach_pkg::WHOLE_W-1:0]     m_rpm_whole,
    output logic [tach_pkg::RPS_W-1:0]       m_rps_byte
);

    tach_pkg::tach_cmd_t cmd;
    tach_pkg::tach_sts_t sts;

    tach_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tach_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_action        (s_action),
        .s_sample        (s_sample),
        .s_period_ms     (s_period_ms),
        .m_rising_count  (m_rising_count),
        .m_falling_count (m_falling_count),
        .m_is_high       (m_is_high),
        .m_is_low        (m_is_low),
        .m_rpm_fixed     (m_rpm_fixed),
        .m_rpm_whole     (m_rpm_whole),
        .m_rps_byte      (m_rps_byte)
    );

endmodule

@@ rtl/core/tach_checker.sv @@
module tach_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [tach_pkg::CNT_W-1:0]       m_rising_count,
    input logic [tach_pkg::CNT_W-1:0]       m_falling_count,
    input logic                             m_is_high,
    input logic                             m_is_low,
    input logic [tach_pkg::RPM_W-1:0]       m_rpm_fixed,
    input logic [tach_pkg::WHOLE_W-1:0]     m_rpm_whole
);

    // A stalled result holds its item
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rpm_fixed)
            && $stable(m_rising_count) && $stable(m_falling_count))
        else $error("result changed while stalled");

    // One item in flight: no accept on the cycle after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an item is in flight");

    // Flags are never both set on a valid result
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_is_high && m_is_low))
        else $error("high and low flags both set");

    // Whole rpm agrees with the fixed-point rpm
    a_whole: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_rpm_fixed[31:20] != '0) ? (m_rpm_whole == 16'hFFFF)
                     : (m_rpm_whole == m_rpm_fixed[19:4])))
        else $error("whole rpm mismatch");

endmodule

bind tachometer_edge_rpm tach_checker u_tach_checker (.*);
